FILE: design/ecb_pkg.sv
// ecb_pkg: shared types, constants and pixel arithmetic for edge_contrast_blur
// no dependencies; imported by ecb_front, ecb_back, edge_contrast_blur and the bench

package ecb_pkg;

	// configuration register file
	localparam int CFG_W     = 13;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// item kinds
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// luma contrast threshold on r+g+b sums
	localparam logic [9:0] CONTRAST_LIMIT = 10'd24;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       smoothed;
		logic       frame_end;
	} out_beat_t;

	// classified pixel handed from front to back
	typedef struct packed {
		rgb_t centre;
		rgb_t east;
		rgb_t south;
		logic flush;
		logic interior;
		logic frame_end;
	} work_t;

	// r+g+b of one pixel
	function automatic logic [9:0] luma(input rgb_t p);
		luma = {2'b00, p.red} + {2'b00, p.green} + {2'b00, p.blue};
	endfunction

	// floor((4c + n + s + e + w) / 8) for one channel
	function automatic logic [7:0] blur_chan(input logic [7:0] c, input logic [7:0] n,
		input logic [7:0] s, input logic [7:0] e, input logic [7:0] w);
		logic [10:0] sum;
		sum = {1'b0, c, 2'b00} + {3'b000, n} + {3'b000, s} + {3'b000, e} + {3'b000, w};
		blur_chan = sum[10:3];
	endfunction

endpackage

FILE: design/ecb_ram.sv
// ecb_ram: generic line memory, one write port and RD_PORTS registered read ports
// no dependencies

module ecb_ram #(
	parameter int WIDTH    = 24,
	parameter int DEPTH    = 4096,
	parameter int RD_PORTS = 1
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [$clog2(DEPTH)-1:0]                waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [RD_PORTS-1:0][$clog2(DEPTH)-1:0]  raddr,
	output logic [RD_PORTS-1:0][WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q  [RD_PORTS];

	// write, reads return the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			for (int i = 0; i < RD_PORTS; i++) begin
				rd_q[i] <= mem_q[raddr[i]];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < RD_PORTS; i++) begin
			rdata[i] = rd_q[i];
		end
	end

endmodule

FILE: design/ecb_queue.sv
// ecb_queue: small flop queue between front and back
// no dependencies

module ecb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/ecb_front.sv
// ecb_front: configuration, frame position, classification and pending-row buffer
// depends on ecb_pkg and ecb_ram

module ecb_front import ecb_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [REG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         push,
	output logic                         full,
	input  in_beat_t                     pixel,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [$clog2(MAX_WIDTH)-1:0] q_col,
	output work_t                        q_work
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int EW0 = (WW > HW) ? WW : HW;
	localparam int EW  = (EW0 > CFG_W) ? EW0 : CFG_W;
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	logic [XW-1:0] wm1_q;
	logic [HW-1:0] h_q;
	logic          w_small_q;
	logic          h_small_q;
	logic [XW-1:0] col_q;
	logic [HW-1:0] row_q;

	logic          valid_s1;
	logic [XW-1:0] col_s1;
	rgb_t          south_s1;
	logic          flush_s1;
	logic          interior_s1;
	logic          frame_end_s1;

	logic [EW-1:0] cfg_ext;
	logic [EW-1:0] new_w;
	logic [EW-1:0] new_h;
	logic          take;
	logic          last_col;
	logic          draining;
	logic          is_flush;
	logic          do_store;
	logic          do_drain;
	logic          emit;
	logic          interior;
	rgb_t          pix;
	logic [1:0][XW-1:0] rd_addr;
	logic [1:0][23:0]   rd_data;

	// effective dimensions of a register write
	always_comb begin
		cfg_ext = EW'(cfg_data);
		if (cfg_data == '0) begin
			new_w = EW'(1);
			new_h = EW'(1);
		end else begin
			new_w = (cfg_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : cfg_ext;
			new_h = (cfg_ext > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : cfg_ext;
		end
	end

	// classification of the incoming beat
	assign full     = valid_s1 && q_full;
	assign take     = push && !full;
	assign last_col = (col_q == wm1_q);
	assign draining = (row_q == h_q);
	assign is_flush = (pixel.mode == MODE_FLUSH);
	assign do_store = take && !is_flush && !draining;
	assign do_drain = take && is_flush && draining;
	assign emit     = (do_store && (row_q != '0)) || do_drain;
	assign interior = !w_small_q && !h_small_q && (row_q != HW'(1)) && (col_q != '0)
		&& !last_col && !is_flush;

	assign pix.red   = pixel.in_red;
	assign pix.green = pixel.in_green;
	assign pix.blue  = pixel.in_blue;

	// centre at the column, east one to the right (the column itself at the last column)
	assign rd_addr[0] = col_q;
	assign rd_addr[1] = last_col ? col_q : col_q + XW'(1);

	ecb_ram #(
		.WIDTH    (24),
		.DEPTH    (MAX_WIDTH),
		.RD_PORTS (2)
	) u_pending (
		.clk   (clk),
		.we    (do_store),
		.waddr (col_q),
		.wdata (pix),
		.re    (take),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// registers and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q     <= XW'(RST_W - 1);
			h_q       <= HW'(RST_H);
			w_small_q <= (RST_W < 3);
			h_small_q <= (RST_H < 3);
			col_q     <= '0;
			row_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					wm1_q     <= XW'(new_w - EW'(1));
					w_small_q <= (new_w < EW'(3));
				end
				REG_HEIGHT: begin
					h_q       <= HW'(new_h);
					h_small_q <= (new_h < EW'(3));
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (do_store || do_drain) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= do_drain ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= emit;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, line buffer data arrives alongside
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1       <= col_q;
			south_s1     <= pix;
			flush_s1     <= is_flush;
			interior_s1  <= interior;
			frame_end_s1 <= is_flush && last_col;
		end
	end

	assign q_push           = valid_s1 && !q_full;
	assign q_col            = col_s1;
	assign q_work.centre    = rd_data[0];
	assign q_work.east      = rd_data[1];
	assign q_work.south     = south_s1;
	assign q_work.flush     = flush_s1;
	assign q_work.interior  = interior_s1;
	assign q_work.frame_end = frame_end_s1;

endmodule

FILE: design/ecb_back.sv
// ecb_back: prior-row buffer, contrast test, blur and result register
// depends on ecb_pkg and ecb_ram

module ecb_back import ecb_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	input  work_t                        q_work,
	output logic                         q_pop,
	output out_beat_t                    result,
	output logic                         empty,
	input  logic                         pop
);

	localparam int XW = $clog2(MAX_WIDTH);

	logic          valid_s2;
	logic [XW-1:0] col_s2;
	work_t         work_s2;
	rgb_t          west_q;
	logic          out_valid_q;
	out_beat_t     out_q;

	logic          adv_s2;
	logic [0:0][XW-1:0] rd_addr;
	logic [0:0][23:0]   rd_data;
	rgb_t          north;
	logic [9:0]    lum [5];
	logic [9:0]    lo;
	logic [9:0]    hi;
	logic          smooth;
	rgb_t          blur;
	rgb_t          o;

	assign adv_s2     = valid_s2 && (!out_valid_q || pop);
	assign q_pop      = !q_empty && (!valid_s2 || adv_s2);
	assign rd_addr[0] = q_col;
	assign north      = rd_data[0];

	ecb_ram #(
		.WIDTH    (24),
		.DEPTH    (MAX_WIDTH),
		.RD_PORTS (1)
	) u_prior (
		.clk   (clk),
		.we    (adv_s2 && !work_s2.flush),
		.waddr (col_s2),
		.wdata (o),
		.re    (q_pop),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// contrast over the five-point neighborhood
	always_comb begin
		lum[0] = luma(work_s2.centre);
		lum[1] = luma(north);
		lum[2] = luma(work_s2.south);
		lum[3] = luma(work_s2.east);
		lum[4] = luma(west_q);
		lo = lum[0];
		hi = lum[0];
		for (int i = 1; i < 5; i++) begin
			if (lum[i] < lo) begin
				lo = lum[i];
			end
			if (lum[i] > hi) begin
				hi = lum[i];
			end
		end
		smooth = work_s2.interior && ((hi - lo) > CONTRAST_LIMIT);
	end

	// blur per channel and selection
	always_comb begin
		blur.red   = blur_chan(work_s2.centre.red, north.red, work_s2.south.red,
			work_s2.east.red, west_q.red);
		blur.green = blur_chan(work_s2.centre.green, north.green, work_s2.south.green,
			work_s2.east.green, west_q.green);
		blur.blue  = blur_chan(work_s2.centre.blue, north.blue, work_s2.south.blue,
			work_s2.east.blue, west_q.blue);
		o = smooth ? blur : work_s2.centre;
	end

	// stage 2 and result valid, west feedback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			west_q      <= '0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s2 && !work_s2.flush) begin
				west_q <= o;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s2  <= q_col;
			work_s2 <= q_work;
		end
		if (adv_s2) begin
			out_q.out_red   <= o.red;
			out_q.out_green <= o.green;
			out_q.out_blue  <= o.blue;
			out_q.smoothed  <= smooth;
			out_q.frame_end <= work_s2.frame_end;
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

FILE: design/edge_contrast_blur.sv
// edge_contrast_blur: contrast-gated five-point blur over an RGB888 raster, one row of delay
// path: an accepted beat passes stage 1, the queue, stage 2 and the result register
// throughput: one beat per cycle unless the receiver holds off pop and the queue fills; the
// pending line buffer has two read ports and one write port
// reset: control state clears, width/height return to 640/480; line buffers are not cleared
// depends on ecb_pkg, ecb_ram, ecb_queue, ecb_front, ecb_back

module edge_contrast_blur import ecb_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  in_beat_t             pixel,
	output logic                 empty,
	input  logic                 pop,
	output out_beat_t            result
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int QW = XW + $bits(work_t);

	logic          f_push;
	logic [XW-1:0] f_col;
	work_t         f_work;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_dout;
	logic [XW-1:0] b_col;
	work_t         b_work;

	ecb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_col     (f_col),
		.q_work    (f_work)
	);

	ecb_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    ({f_col, f_work}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_col  = q_dout[QW-1 -: XW];
	assign b_work = q_dout[$bits(work_t)-1:0];

	ecb_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_col   (b_col),
		.q_work  (b_work),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

FILE: dv/tb_edge_contrast_blur.sv
`timescale 1ns / 1ps
// tb_edge_contrast_blur: self-checking bench for the contrast-gated five-point blur
// depends on ecb_pkg and the edge_contrast_blur rtl; keeps its own pixel predictor and
// checks every result beat in order against it under random idling on both sides

module tb_edge_contrast_blur;
	import ecb_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 push;
	logic                 full;
	in_beat_t             pixel;
	logic                 empty;
	logic                 pop;
	out_beat_t            result;

	edge_contrast_blur dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	always #10 clk = ~clk;

	// predictor state: line buffers, neighbours, raster position, register copies
	bit [23:0]        above_out_row [DEF_MAX_WIDTH];
	bit [23:0]        held_in_row   [DEF_MAX_WIDTH];
	bit [23:0]        west_out;
	bit [23:0]        east_in;
	int unsigned      cur_col;
	int unsigned      cur_row;
	int unsigned      emit_count;
	bit [CFG_W-1:0]   cfg_width;
	bit [CFG_W-1:0]   cfg_height;

	out_beat_t        expected_pixels[$];
	int unsigned      fail_count = 0;
	int unsigned      items_sent = 0;
	int unsigned      tx_idle_pct = 27;
	int unsigned      rx_idle_pct = 27;
	bit               rx_hold_req = 1'b0;

	function automatic int unsigned eff_dim(input bit [CFG_W-1:0] v, input int unsigned cap);
		if (v == 0) return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic int luma_of(input bit [23:0] p);
		return int'(p[23:16]) + int'(p[15:8]) + int'(p[7:0]);
	endfunction

	function automatic void restart_position();
		west_out   = '0;
		east_in    = '0;
		cur_col    = 0;
		cur_row    = 0;
		emit_count = 0;
	endfunction

	// one accepted beat through the predictor; returns 0 when the block ignores it
	function automatic bit blur_predict(input in_beat_t b);
		int unsigned w, h, x, total;
		int          lum[5];
		int          lo, hi, v;
		bit [23:0]   pix, c, o, nb;
		bit          sm;
		out_beat_t   r;
		w     = eff_dim(cfg_width, DEF_MAX_WIDTH);
		h     = eff_dim(cfg_height, DEF_MAX_HEIGHT);
		total = w * h;
		x     = (cur_col >= w) ? w - 1 : cur_col;
		sm    = 1'b0;
		if (b.mode == MODE_FLUSH) begin
			if (cur_row < h) return 1'b0;
			o = held_in_row[x];
		end else begin
			if (cur_row >= h) return 1'b0;
			pix = {b.in_red, b.in_green, b.in_blue};
			// first row only fills the line buffer
			if (cur_row == 0) begin
				held_in_row[x] = pix;
				if (x + 1 >= w) begin
					cur_col = 0;
					cur_row = 1;
				end else begin
					cur_col = x + 1;
				end
				return 1'b1;
			end
			c = held_in_row[x];
			o = c;
			// interior pixel: north and west already emitted, east and south original
			if (w >= 3 && h >= 3 && cur_row != 1 && x != 0 && x + 1 < w) begin
				nb      = above_out_row[x];
				east_in = held_in_row[x + 1];
				lum[0]  = luma_of(c);
				lum[1]  = luma_of(nb);
				lum[2]  = luma_of(pix);
				lum[3]  = luma_of(east_in);
				lum[4]  = luma_of(west_out);
				lo = lum[0];
				hi = lum[0];
				for (int i = 1; i < 5; i++) begin
					if (lum[i] < lo) lo = lum[i];
					if (lum[i] > hi) hi = lum[i];
				end
				if (hi - lo > int'(CONTRAST_LIMIT)) begin
					for (int sh = 0; sh <= 16; sh += 8) begin
						v = 4 * int'(c[sh +: 8]) + int'(nb[sh +: 8]) + int'(pix[sh +: 8])
							+ int'(east_in[sh +: 8]) + int'(west_out[sh +: 8]);
						o[sh +: 8] = 8'(v >> 3);
					end
					sm = 1'b1;
				end
			end
			above_out_row[x] = o;
			west_out         = o;
			held_in_row[x]   = pix;
		end
		r.out_red   = o[23:16];
		r.out_green = o[15:8];
		r.out_blue  = o[7:0];
		r.smoothed  = sm;
		r.frame_end = (emit_count + 1 >= total);
		expected_pixels.push_back(r);
		emit_count++;
		if (b.mode == MODE_FLUSH) begin
			if (x + 1 >= w) restart_position();
			else cur_col = x + 1;
		end else begin
			if (x + 1 >= w) begin
				cur_col = 0;
				cur_row++;
			end else begin
				cur_col = x + 1;
			end
		end
		return 1'b1;
	endfunction

	// beat builders
	function automatic in_beat_t pix_beat(input bit [23:0] rgb);
		in_beat_t b;
		b.mode     = MODE_PIXEL;
		b.in_red   = rgb[23:16];
		b.in_green = rgb[15:8];
		b.in_blue  = rgb[7:0];
		return b;
	endfunction

	function automatic in_beat_t flush_beat();
		in_beat_t b;
		b          = pix_beat(24'($urandom));
		b.mode     = MODE_FLUSH;
		return b;
	endfunction

	// pixel near a frame tone so the contrast falls on both sides of the limit
	function automatic in_beat_t make_pixel(input int unsigned spread, input rgb_t tone);
		if (spread >= 255 || $urandom_range(49) == 0) return pix_beat(24'($urandom));
		return pix_beat({tone.red + 8'($urandom_range(spread)),
			tone.green + 8'($urandom_range(spread)),
			tone.blue + 8'($urandom_range(spread))});
	endfunction

	function automatic rgb_t pick_tone(input int unsigned spread);
		rgb_t t;
		int unsigned top;
		top     = (spread >= 255) ? 0 : 255 - spread;
		t.red   = 8'($urandom_range(top));
		t.green = 8'($urandom_range(top));
		t.blue  = 8'($urandom_range(top));
		return t;
	endfunction

	// send one beat: random idle cycles first, then hold until accepted
	task automatic send_beat(input in_beat_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		pixel <= b;
		push  <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		if (blur_predict(b)) items_sent++;
	endtask

	// sender pause until every expected beat has come back
	task automatic await_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	// drain, then idle so beats without a result leave the pipeline
	task automatic await_idle();
		await_results();
		repeat (8) @(posedge clk);
	endtask

	// write both size registers; every write restarts the frame position
	task automatic set_size(input int unsigned w_val, input int unsigned h_val);
		await_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w_val[CFG_W-1:0];
		@(posedge clk);
		cfg_width = w_val[CFG_W-1:0];
		restart_position();
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h_val[CFG_W-1:0];
		@(posedge clk);
		cfg_height = h_val[CFG_W-1:0];
		restart_position();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one frame from position zero, cut after limit beats; stray beats mixed in
	task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg,
		input int unsigned spread, input bit reconfig, input int unsigned limit);
		int unsigned w, h, n_pix;
		rgb_t        tone;
		if (reconfig) set_size(w_reg, h_reg);
		w     = eff_dim(cfg_width, DEF_MAX_WIDTH);
		h     = eff_dim(cfg_height, DEF_MAX_HEIGHT);
		n_pix = w * h;
		tone  = pick_tone(spread);
		for (int unsigned i = 0; i < n_pix + w && i < limit; i++) begin
			// flush while still taking pixels and pixel while draining are both dropped
			if ($urandom_range(99) < 4) begin
				if (i < n_pix) send_beat(flush_beat());
				else send_beat(pix_beat(24'($urandom)));
			end
			if ($urandom_range(199) == 0) await_results();
			if (i < n_pix) send_beat(make_pixel(spread, tone));
			else send_beat(flush_beat());
		end
	endtask

	// result side: check each popped beat, random stalls, long hold on request
	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		if (expected_pixels.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result beat: rgb %h%h%h smoothed %b frame_end %b",
					got.out_red, got.out_green, got.out_blue, got.smoothed, got.frame_end);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
			got.out_blue !== want.out_blue || got.smoothed !== want.smoothed ||
			got.frame_end !== want.frame_end) begin
			fail_count++;
			if (fail_count <= 10)
				$display("result mismatch: expected rgb %h%h%h sm %b fe %b, got rgb %h%h%h sm %b fe %b",
					want.out_red, want.out_green, want.out_blue, want.smoothed, want.frame_end,
					got.out_red, got.out_green, got.out_blue, got.smoothed, got.frame_end);
		end
	endtask

	initial begin : result_monitor
		int unsigned hold_left;
		hold_left = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0) check_result(result);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// reset size 640: one full first row and a few of the second
	task automatic test_reset_size();
		for (int i = 0; i < 646; i++) send_beat(make_pixel(255, '0));
	endtask

	// 4x3 frame straddling the contrast limit, stray beats, 1x1 frame from zero registers
	task automatic test_directed();
		set_size(4, 3);
		send_beat(flush_beat());
		for (int i = 0; i < 8; i++) send_beat(pix_beat(24'h000000));
		send_beat(pix_beat(24'hffffff));
		send_beat(pix_beat(24'h080808));
		send_beat(pix_beat(24'h080809));
		send_beat(pix_beat(24'h000000));
		send_beat(pix_beat(24'hffffff));
		for (int i = 0; i < 4; i++) send_beat(flush_beat());
		set_size(0, 0);
		send_beat(pix_beat(24'($urandom)));
		send_beat(pix_beat(24'($urandom)));
		send_beat(flush_beat());
	endtask

	// widest row, first part of the top row only
	task automatic test_wide_rows();
		run_frame(4096, 3, 20, 1'b1, 120);
	endtask

	// clamped height, then clamped width, only the first beats of each
	task automatic test_tall_frame();
		run_frame(3, 8191, 12, 1'b1, 15);
		run_frame(8191, 1, 255, 1'b1, 40);
	endtask

	// receiver holds off while rows keep coming, then the sender waits for all results
	task automatic test_backpressure();
		set_size(6, 5);
		for (int i = 0; i < 6; i++) send_beat(make_pixel(255, '0));
		rx_hold_req = 1'b1;
		for (int i = 0; i < 18; i++) send_beat(make_pixel(255, '0));
		await_results();
		for (int i = 0; i < 6; i++) send_beat(make_pixel(255, '0));
		for (int i = 0; i < 6; i++) send_beat(flush_beat());
	endtask

	// random small frames up to the item budget, some cut short, some repeated without
	// a register write
	task automatic test_random_frames();
		int unsigned w_reg, h_reg, spread, limit;
		int unsigned spreads[7] = '{0, 3, 6, 9, 12, 20, 255};
		bit          cut, last_cut, reconfig;
		last_cut = 1'b1;
		while (items_sent < 1550) begin
			// a stretch with no idling on either side
			if (items_sent >= 1100 && items_sent < 1350) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = 27;
				rx_idle_pct = 27;
			end
			case ($urandom_range(19))
				0:       w_reg = 0;
				1:       w_reg = $urandom_range(10, 24);
				default: w_reg = $urandom_range(1, 9);
			endcase
			h_reg    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
			spread   = spreads[$urandom_range(6)];
			reconfig = last_cut || $urandom_range(99) >= 30;
			cut      = $urandom_range(99) < 10;
			limit    = cut ? $urandom_range(0, 60) : 32'hffff_ffff;
			run_frame(w_reg, h_reg, spread, reconfig, limit);
			last_cut = cut;
		end
		tx_idle_pct = 27;
		rx_idle_pct = 27;
	endtask

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data  <= '0;
		cfg_width  = CFG_W'(RESET_WIDTH);
		cfg_height = CFG_W'(RESET_HEIGHT);
		restart_position();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_size();
		test_directed();
		test_wide_rows();
		test_tall_frame();
		test_backpressure();
		test_random_frames();
		await_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
design/ecb_pkg.sv
design/ecb_ram.sv
design/ecb_queue.sv
design/ecb_front.sv
design/ecb_back.sv
design/edge_contrast_blur.sv
dv/tb_edge_contrast_blur.sv
